>>> sv/greedy_word_wrap_macros.svh
// Assertion macros for the greedy word wrap block.
// Included by the top level; no other dependencies.
`ifndef GREEDY_WORD_WRAP_MACROS_SVH
`define GREEDY_WORD_WRAP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property every clock edge outside reset
`define GWW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property every clock edge, reset included
`define GWW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GWW_ASSERT(lbl, clk, rstn, prop, msg)
`define GWW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/gww_pkg.sv
// Shared types and constants for the greedy word wrap block.
// No dependencies.
package gww_pkg;

  localparam int unsigned MaxWord      = 32;
  localparam logic [7:0]  SpaceChar    = 8'h20;
  localparam logic [7:0]  LineSat      = 8'hFF;
  localparam logic [7:0]  WidthDefault = 8'd40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BREAK,
    ST_SPACE,
    ST_WORD,
    ST_FINISH
  } gww_state_e;

endpackage

>>> sv/gww_if.sv
// Valid/ready stream interfaces for the text input and the wrapped output.
// No dependencies.
interface gww_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface gww_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_end;
  logic       word_truncated;
  logic       last;

  modport source (output valid, output out_byte, output line_end,
                  output word_truncated, output last, input ready);
  modport sink   (input valid, input out_byte, input line_end,
                  input word_truncated, input last, output ready);
endinterface

>>> sv/greedy_word_wrap.sv
// Greedy word wrap top level: word buffer, line sequencer and output register.
// Depends on gww_pkg, gww_if.sv and greedy_word_wrap_macros.svh.
//
// Text enters one byte per transfer on text_i; wrapped lines leave on line_o as
// characters and line-end markers. A non-space byte, or a space that closes no
// word, is taken in idle and yields nothing. A space that closes a word, or end
// of text, holds text_i not ready through a decision state, then one result
// after another (separator or break, each stored character, and the final line end
// on end of text), as the word buffer is read back one entry per cycle into the
// output register unless the output stalls. The user must write line_width via
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
`include "greedy_word_wrap_macros.svh"

module greedy_word_wrap #(
  parameter int unsigned MAX_WORD = gww_pkg::MaxWord
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  gww_in_if.sink     text_i,
  gww_out_if.source  line_o
);
  import gww_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_WORD + 1);
  localparam int unsigned IdxW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  gww_state_e state_q, state_d;

  logic [LenW-1:0] wlen_q, wlen_d;
  logic [7:0]      llen_q, llen_d;
  logic            any_q, any_d;
  logic            ovf_q, ovf_d;
  logic            is_end_q, is_end_d;
  logic [7:0]      width_q;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [7:0]      word_mem [MAX_WORD];
  logic [7:0]      rdata_q;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_end_q, out_trunc_q, out_last_q;

  // Result offered by the sequencer this cycle
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_end, emit_trunc, emit_last;
  logic            slot_free, load;

  logic            in_xfer;
  logic            is_space;
  logic [8:0]      need;
  logic            too_long;
  logic            word_done;
  logic [7:0]      llen_inc;

  assign in_xfer   = text_i.valid && text_i.ready;
  assign is_space  = (text_i.text_byte == SpaceChar);
  assign slot_free = !out_valid_q || line_o.ready;
  assign load      = emit && slot_free;
  assign llen_inc  = (llen_q == LineSat) ? LineSat : llen_q + 8'd1;
  assign need      = {1'b0, llen_q} + 9'd1 + 9'(wlen_q);
  assign too_long  = need > {1'b0, width_q};
  assign word_done = (LenW'(idx_q) == wlen_q - LenW'(1));

  assign text_i.ready = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (text_i.end_of_text || (is_space && wlen_q != '0))) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (wlen_q == '0) begin
          state_d = ST_FINISH;
        end else if (llen_q != 8'd0 && too_long) begin
          state_d = ST_BREAK;
        end else if (llen_q != 8'd0) begin
          state_d = ST_SPACE;
        end else begin
          state_d = ST_WORD;
        end
      end
      ST_BREAK, ST_SPACE: begin
        if (load) begin
          state_d = ST_WORD;
        end
      end
      ST_WORD: begin
        if (load && word_done) begin
          state_d = is_end_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (load || !emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result selection and state updates
  always_comb begin
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_end   = 1'b0;
    emit_trunc = 1'b0;
    emit_last  = 1'b0;
    wlen_d     = wlen_q;
    llen_d     = llen_q;
    any_d      = any_q;
    ovf_d      = ovf_q;
    is_end_d   = is_end_q;
    idx_d      = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          is_end_d = text_i.end_of_text;
          if (!text_i.end_of_text && !is_space) begin
            if (wlen_q < LenW'(MAX_WORD)) begin
              wlen_d = wlen_q + LenW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      ST_DECIDE: begin
        idx_d = '0;
      end
      ST_BREAK: begin
        emit     = 1'b1;
        emit_end = 1'b1;
        if (load) begin
          llen_d = 8'd0;
          any_d  = 1'b1;
        end
      end
      ST_SPACE: begin
        emit      = 1'b1;
        emit_byte = SpaceChar;
        if (load) begin
          llen_d = llen_inc;
        end
      end
      ST_WORD: begin
        emit       = 1'b1;
        emit_byte  = rdata_q;
        emit_trunc = ovf_q;
        emit_last  = word_done && !is_end_q;
        if (load) begin
          llen_d = llen_inc;
          idx_d  = idx_q + IdxW'(1);
          if (word_done) begin
            wlen_d = '0;
            ovf_d  = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        emit      = (llen_q != 8'd0) || !any_q;
        emit_end  = 1'b1;
        emit_last = 1'b1;
        if (load || !emit) begin
          wlen_d   = '0;
          llen_d   = 8'd0;
          any_d    = 1'b0;
          ovf_d    = 1'b0;
          is_end_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and text state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wlen_q   <= '0;
      llen_q   <= 8'd0;
      any_q    <= 1'b0;
      ovf_q    <= 1'b0;
      is_end_q <= 1'b0;
      idx_q    <= '0;
      width_q  <= WidthDefault;
    end else begin
      state_q  <= state_d;
      wlen_q   <= wlen_d;
      llen_q   <= llen_d;
      any_q    <= any_d;
      ovf_q    <= ovf_d;
      is_end_q <= is_end_d;
      idx_q    <= idx_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
    end
  end

  // Word buffer: store characters, read the entry the sequencer moves to
  always_ff @(posedge clk_i) begin
    if (in_xfer && !text_i.end_of_text && !is_space && wlen_q < LenW'(MAX_WORD)) begin
      word_mem[wlen_q[IdxW-1:0]] <= text_i.text_byte;
    end
    rdata_q <= word_mem[idx_d];
  end

  // Output register: hold a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= emit_byte;
      out_end_q   <= emit_end;
      out_trunc_q <= emit_trunc;
      out_last_q  <= emit_last;
    end
  end

  assign line_o.valid          = out_valid_q;
  assign line_o.out_byte       = out_byte_q;
  assign line_o.line_end       = out_end_q;
  assign line_o.word_truncated = out_trunc_q;
  assign line_o.last           = out_last_q;

  `GWW_ASSERT_ALWAYS(a_wlen_bound, clk_i, wlen_q <= LenW'(MAX_WORD), "word length over buffer size")
  `GWW_ASSERT(a_word_nonempty, clk_i, rst_ni, (state_q == ST_WORD) |-> (wlen_q != '0), "word stream with empty buffer")
  `GWW_ASSERT(a_end_clean, clk_i, rst_ni, (out_valid_q && out_end_q) |-> (out_byte_q == 8'd0 && !out_trunc_q), "line end carries data")
  `GWW_ASSERT(a_busy_no_input, clk_i, rst_ni, (state_q != ST_IDLE) |-> !text_i.ready, "input taken during flush")

endmodule
